/* hw/rtl/sfd_pkg.sv */
// Shared types and constants for the stereo feedback delay.
// Holds the tanh table (built at elaboration), register indexes and stage numbering.
// No dependencies.
package sfd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 14;
    localparam int DECAY_W   = 16;
    localparam int MIX_W     = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX         = 2'd3;

    localparam logic [DELAY_W-1:0] DELAY_RST = 14'd4800;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd2048;
    localparam logic [MIX_W-1:0]   MIX_RST   = 15'd16384;

    // Pipeline stages: A holds the read data, F holds the value to write back.
    localparam int NSTG  = 6;
    localparam int STG_A = 0;
    localparam int STG_B = 1;
    localparam int STG_C = 2;
    localparam int STG_D = 3;
    localparam int STG_E = 4;
    localparam int STG_F = 5;

    // Output FIFO and outstanding-item credit.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

    typedef struct packed {
        logic [DECAY_W-1:0] decay;
        logic [MIX_W-1:0]   mix;
    } t_gains;

    // tanh over [0,4) in 256 segments of 1/64, Q1.15 magnitudes.
    localparam int          TANH_SEGS = 256;
    localparam logic [63:0] TANH_T1   = 64'd33551702;
    localparam logic [63:0] Q31_ONE   = 64'd2147483648;

    typedef logic [SAMPLE_W-1:0] t_tanh_tab [0:TANH_SEGS];

    // Restoring shift and subtract quotient, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Recurrence tanh(a+b) = (tanh a + tanh b) / (1 + tanh a * tanh b) in Q.31.
    function automatic t_tanh_tab build_tanh();
        t_tanh_tab   tab;
        logic [63:0] t;
        logic [63:0] den;
        t      = 64'd0;
        tab[0] = '0;
        for (int k = 1; k <= TANH_SEGS; k++) begin
            den    = Q31_ONE + ((t * TANH_T1) >> 31);
            t      = udiv64((t + TANH_T1) << 31, den);
            tab[k] = SAMPLE_W'((t + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh();

endpackage

/* hw/rtl/sfd_in_if.sv */
// Input stream channel of the stereo feedback delay: one stereo pair per item.
// Depends on nothing.
interface sfd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

/* hw/rtl/sfd_out_if.sv */
// Output stream channel of the stereo feedback delay: one stereo pair per item.
// Depends on nothing.
interface sfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* hw/rtl/stereo_feedback_delay_saturating.sv */
// Stereo feedback delay with a saturating (tanh) feedback path.
// Top level: configuration registers, write position, stage control, output FIFO.
// Uses sfd_pkg, sfd_in_if, sfd_out_if and sfd_channel.
//
// Each accepted item is one stereo pair in Q1.15. Per channel the block reads the
// sample written delay items ago, stores tanh(x + decay*delayed) at the write
// position and returns x + mix*delayed saturated to Q1.15. The result of an item
// passes stages A, B and C and then reaches the output through an 8-entry
// output FIFO; the input keeps flowing while results wait, until eight items are
// outstanding. The write-back of an item lands in the store from stage F, so an
// item may not enter while the one it reads from is still in the first four
// pipeline stages. With both delays at 5 or more the block takes one item per
// cycle while the output FIFO has credit; a delay of 1 to 4 makes the input wait
// on that channel. The stores need no clearing pass after reset: the write position
// and a wrapped flag tell which entries were written, and an entry not yet written
// reads as zero. STORE_DEPTH must be a power of two; delays are taken modulo it,
// and a delay of zero reads the oldest entry (a full store length back).
// Configuration writes are taken at any edge with i_cfg_we high and are meant to
// happen only while no item is in flight.
module stereo_feedback_delay_saturating #(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sfd_in_if.sink                           i_in,
    sfd_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfd_pkg::CFG_W-1:0]        i_cfg_data
);
    import sfd_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic [DELAY_W-1:0] r_delay_l;
    logic [DELAY_W-1:0] r_delay_r;
    t_gains             r_gain;

    logic [AW-1:0]      r_wp;
    logic               r_wrapped;
    logic [NSTG-1:0]    r_stg_v;
    logic [AW-1:0]      r_stg_wp [NSTG];

    logic               haz_l;
    logic               haz_r;
    logic               accept;
    logic               deliver;
    logic [CNT_W-1:0]   r_cnt;

    logic signed [15:0] y_l;
    logic signed [15:0] y_r;
    logic signed [15:0] r_fifo_l [FIFO_DEPTH];
    logic signed [15:0] r_fifo_r [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_fcnt;

    // Configuration registers: keep only the low bits of each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_l    <= DELAY_RST;
            r_delay_r    <= DELAY_RST;
            r_gain.decay <= DECAY_RST;
            r_gain.mix   <= MIX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY_LEFT:  r_delay_l    <= i_cfg_data[DELAY_W-1:0];
                CFG_DELAY_RIGHT: r_delay_r    <= i_cfg_data[DELAY_W-1:0];
                CFG_DECAY:       r_gain.decay <= i_cfg_data[DECAY_W-1:0];
                CFG_MIX:         r_gain.mix   <= i_cfg_data[MIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Accept only out of reset, with credit left in the output FIFO and no
    // pending write-back that the new item would read.
    assign i_in.ready = i_rst_n && (r_cnt < CNT_W'(FIFO_DEPTH)) && !haz_l && !haz_r;
    assign accept     = i_in.valid && i_in.ready;
    assign deliver    = o_out.valid && o_out.ready;

    // Advance the shared write position; remember once it has gone all around.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (accept) begin
            r_wp <= r_wp + 1'b1;
            if (&r_wp) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    // Stage control: valid bit and write position travel with each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= '0;
        end else begin
            r_stg_v <= {r_stg_v[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg_wp[STG_A] <= r_wp;
        for (int s = STG_B; s < NSTG; s++) begin
            r_stg_wp[s] <= r_stg_wp[s-1];
        end
    end

    sfd_channel #(.ADDR_W(AW)) u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_x       (i_in.left_in),
        .i_delay   (r_delay_l),
        .i_gain    (r_gain),
        .i_wp      (r_wp),
        .i_wrapped (r_wrapped),
        .i_stg_v   (r_stg_v),
        .i_stg_wp  (r_stg_wp),
        .o_hazard  (haz_l),
        .o_y       (y_l)
    );

    sfd_channel #(.ADDR_W(AW)) u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_x       (i_in.right_in),
        .i_delay   (r_delay_r),
        .i_gain    (r_gain),
        .i_wp      (r_wp),
        .i_wrapped (r_wrapped),
        .i_stg_v   (r_stg_v),
        .i_stg_wp  (r_stg_wp),
        .o_hazard  (haz_r),
        .o_y       (y_r)
    );

    // Outstanding items: accepted but not yet taken at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(accept) - CNT_W'(deliver);
        end
    end

    // Output FIFO: push when the wet result leaves stage C, pop on delivery.
    always_ff @(posedge i_clk) begin
        if (r_stg_v[STG_C]) begin
            r_fifo_l[r_wr_ptr] <= y_l;
            r_fifo_r[r_wr_ptr] <= y_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
        end else begin
            if (r_stg_v[STG_C]) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (deliver) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fcnt <= r_fcnt + CNT_W'(r_stg_v[STG_C]) - CNT_W'(deliver);
        end
    end

    assign o_out.valid     = (r_fcnt != '0);
    assign o_out.left_out  = r_fifo_l[r_rd_ptr];
    assign o_out.right_out = r_fifo_r[r_rd_ptr];

endmodule

/* hw/rtl/sfd_channel.sv */
// One channel of the feedback delay: ring store, forwarding, gain multiplies,
// tanh feedback path and the saturated dry plus wet output. Uses sfd_pkg.
module sfd_channel #(
    parameter int ADDR_W = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [sfd_pkg::SAMPLE_W-1:0] i_x,
    input  logic [sfd_pkg::DELAY_W-1:0]         i_delay,
    input  sfd_pkg::t_gains                     i_gain,
    input  logic [ADDR_W-1:0]                   i_wp,
    input  logic                                i_wrapped,
    input  logic [sfd_pkg::NSTG-1:0]            i_stg_v,
    input  logic [ADDR_W-1:0]                   i_stg_wp [sfd_pkg::NSTG],
    output logic                                o_hazard,
    output logic signed [sfd_pkg::SAMPLE_W-1:0] o_y
);
    import sfd_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] rd;
    logic              fill;

    // stage A
    logic signed [15:0] r_a_x;
    logic [ADDR_W-1:0]  r_a_rd;
    logic               r_a_fill;
    logic [15:0]        r_q;
    logic signed [15:0] delayed;
    logic signed [16:0] decay_s;
    logic signed [15:0] mix_s;
    logic signed [32:0] pd_w;
    logic signed [31:0] pm_w;
    // stage B
    logic signed [15:0] r_b_x;
    logic signed [31:0] r_b_pd;
    logic signed [30:0] r_b_pm;
    logic signed [32:0] u_w;
    logic signed [31:0] wet_w;
    logic signed [17:0] yy;
    logic signed [15:0] n_c_y;
    // stage C
    logic signed [32:0] r_c_u;
    logic signed [15:0] r_c_y;
    logic [32:0]        mag;
    // stage D
    logic               r_d_neg;
    logic               r_d_big;
    logic [7:0]         r_d_idx;
    logic [20:0]        r_d_frac;
    logic [15:0]        lo;
    logic [15:0]        hi;
    logic [9:0]         step;
    // stage E
    logic               r_e_neg;
    logic               r_e_big;
    logic [15:0]        r_e_lo;
    logic [30:0]        r_e_prod;
    logic [31:0]        rnd;
    logic [16:0]        tsum;
    logic [15:0]        tmag;
    logic signed [15:0] n_f_w;
    // stage F and last write
    logic signed [15:0] r_f_w;
    logic               r_lw_v;
    logic [ADDR_W-1:0]  r_lw_addr;
    logic signed [15:0] r_lw_data;

    // Read address, whether that entry was ever written since reset, and the hazard.
    always_comb begin
        rd   = i_wp - ADDR_W'(i_delay);
        fill = i_wrapped || (rd < i_wp);
        o_hazard = 1'b0;
        for (int s = STG_A; s <= STG_D; s++) begin
            o_hazard = o_hazard || (i_stg_v[s] && (i_stg_wp[s] == rd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stg_v[STG_F]) begin
            mem[i_stg_wp[STG_F]] <= r_f_w;
        end
        r_q <= mem[rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_v <= 1'b0;
        end else if (i_stg_v[STG_F]) begin
            r_lw_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stg_v[STG_F]) begin
            r_lw_addr <= i_stg_wp[STG_F];
            r_lw_data <= r_f_w;
        end
    end

    // Stage A: pick the delayed sample (forward pending write-backs), multiply.
    always_comb begin
        if (!r_a_fill) begin
            delayed = '0;
        end else if (i_stg_v[STG_F] && (i_stg_wp[STG_F] == r_a_rd)) begin
            delayed = r_f_w;
        end else if (r_lw_v && (r_lw_addr == r_a_rd)) begin
            delayed = r_lw_data;
        end else begin
            delayed = r_q;
        end
        decay_s = {1'b0, i_gain.decay};
        mix_s   = {1'b0, i_gain.mix};
        pd_w    = 33'(decay_s) * 33'(delayed);
        pm_w    = 32'(mix_s) * 32'(delayed);
    end

    // Stage B: feedback sum in Q.27, wet term added to dry, rounded and saturated.
    always_comb begin
        u_w   = {{5{r_b_x[15]}}, r_b_x, 12'b0} + {r_b_pd[31], r_b_pd};
        wet_w = {{2{r_b_x[15]}}, r_b_x, 14'b0} + {r_b_pm[30], r_b_pm} + 32'sd8192;
        yy    = wet_w[31:14];
        if ((yy[17:15] == 3'b000) || (yy[17:15] == 3'b111)) begin
            n_c_y = yy[15:0];
        end else if (yy[17]) begin
            n_c_y = 16'sh8000;
        end else begin
            n_c_y = 16'sh7FFF;
        end
    end

    // Stage C: magnitude of the feedback sum.
    always_comb begin
        mag = r_c_u[32] ? 33'(-r_c_u) : 33'(r_c_u);
    end

    // Stage D: table lookup and interpolation multiply.
    always_comb begin
        lo   = TANH_TAB[{1'b0, r_d_idx}];
        hi   = TANH_TAB[9'({1'b0, r_d_idx}) + 9'd1];
        step = 10'(hi - lo);
    end

    // Stage E: round the interpolation, clamp and restore the sign.
    always_comb begin
        rnd  = {1'b0, r_e_prod} + 32'd1048576;
        tsum = {1'b0, r_e_lo} + {6'b0, rnd[31:21]};
        if (r_e_big || (tsum > 17'd32767)) begin
            tmag = 16'd32767;
        end else begin
            tmag = tsum[15:0];
        end
        n_f_w = r_e_neg ? -$signed(tmag) : $signed(tmag);
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= i_x;
        r_a_rd   <= rd;
        r_a_fill <= fill;
        r_b_x    <= r_a_x;
        r_b_pd   <= pd_w[31:0];
        r_b_pm   <= pm_w[30:0];
        r_c_u    <= u_w;
        r_c_y    <= n_c_y;
        r_d_neg  <= r_c_u[32];
        r_d_big  <= |mag[32:29];
        r_d_idx  <= mag[28:21];
        r_d_frac <= mag[20:0];
        r_e_neg  <= r_d_neg;
        r_e_big  <= r_d_big;
        r_e_lo   <= lo;
        r_e_prod <= 31'(step) * 31'(r_d_frac);
        r_f_w    <= n_f_w;
    end

    assign o_y = r_c_y;

endmodule
